// ----- hw/rtl/h2rgb_pkg.sv -----
`timescale 1ns / 1ps

package h2rgb_pkg;

   // Q16 fixed point for saturation, lightness and channel levels
   localparam int unsigned ONE_Q16  = 65536;
   localparam int unsigned HALF_Q16 = 32768;

   // reciprocals: (x * RECIP) >> SHIFT gives floor(x / d) exactly over the input range
   localparam logic [16:0] RECIP_360 = 17'd93207;     // 16-bit x, shift 25
   localparam logic [23:0] RECIP_100 = 24'd10737419;  // 23-bit x, shift 30
   localparam logic [24:0] RECIP_60  = 25'd17895698;  // 24-bit x, shift 30

   localparam logic [8:0] DEG_60  = 9'd60;
   localparam logic [8:0] DEG_120 = 9'd120;
   localparam logic [8:0] DEG_180 = 9'd180;
   localparam logic [8:0] DEG_240 = 9'd240;
   localparam logic [8:0] DEG_360 = 9'd360;

   localparam int NUM_CHAN = 3;

   typedef enum logic [1:0] {
      SEC_RISE,
      SEC_HIGH,
      SEC_FALL,
      SEC_LOW
   } sector_type;

   typedef struct packed {
      sector_type  sel;
      logic [5:0]  weight;
   } sector_info_type;

   function automatic sector_info_type sector_of(input logic [8:0] t);
      sector_info_type r;
      if (t < DEG_60) begin
         r.sel    = SEC_RISE;
         r.weight = t[5:0];
      end else if (t < DEG_180) begin
         r.sel    = SEC_HIGH;
         r.weight = 6'd0;
      end else if (t < DEG_240) begin
         r.sel    = SEC_FALL;
         r.weight = 6'(DEG_240 - t);
      end else begin
         r.sel    = SEC_LOW;
         r.weight = 6'd0;
      end
      return r;
   endfunction

   // Q16 level to byte, rounded half up, clamped to 0..255
   function automatic logic [7:0] to_byte(input logic signed [19:0] v);
      logic [26:0] scaled;
      logic [10:0] r;
      scaled = (27'(v) << 8) - 27'(v) + 27'(HALF_Q16);
      r      = scaled[26:16];
      if (v <= 20'sd0)
         return 8'd0;
      else if (r > 11'd255)
         return 8'd255;
      else
         return r[7:0];
   endfunction

endpackage

// ----- hw/rtl/hsl_to_rgb_converter.sv -----
`timescale 1ns / 1ps

// HSL to RGB color converter.
// Input item on req_: hue in whole degrees (any 16-bit value, taken modulo 360),
// saturation and lightness in percent with PERCENT_FRAC_BITS fractional bits,
// clamped to 100 percent. Result item on rsp_: 8-bit red, green, blue.
// Every input item gives exactly one result item, in order.
// Throughput: one item per cycle unless the receiver stalls. Pipeline: eight
// register stages, seven in the pipeline (clamp and reciprocal multiplies, Q16
// conversion and hue reduction, l*s product, q/p, sector weight product,
// divide-by-60 multiply, level select) and the byte output register.
// A skid register behind the output register absorbs the item in flight when
// the receiver stalls; while it is occupied the pipeline holds and req_tready
// is low, so nothing is lost or repeated. req_tready is a register output.
// Reset (synchronous, active high) empties the pipeline, output and skid
// registers; req_tready is high from the first clock edge in reset on.
// Zero saturation gives grey at the lightness level.

module hsl_to_rgb_converter
   import h2rgb_pkg::*;
#(
   parameter int PERCENT_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // hue_degrees, saturation_pct, lightness_pct

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // red, green, blue
);

   localparam logic [31:0] FULL_PCT = 32'(100) << PERCENT_FRAC_BITS;
   localparam int          PCT_SH   = 16 - PERCENT_FRAC_BITS;

   logic en;

   logic [6:0] vld_ff;

   // stage 1
   logic [15:0] hue, sat, lit, sat_cl, lit_cl;
   logic [22:0] sat_y, lit_y;
   logic [46:0] s1_sprod_ff, s1_lprod_ff;
   logic [32:0] s1_hprod_ff;
   logic [15:0] s1_hue_ff;

   // stage 2
   logic [7:0]  hue_quot;
   logic [16:0] s2_s_ff, s2_l_ff;
   logic [8:0]  s2_hm_ff, s2_hm_in;

   // stage 3
   logic [9:0]  tr_sum, tb_sum;
   logic [33:0] s3_lsp_ff;
   logic [16:0] s3_s_ff, s3_l_ff;
   logic [8:0]  s3_t_ff [NUM_CHAN];
   logic [8:0]  s3_t_in [NUM_CHAN];

   // stage 4
   logic [16:0]        ls;
   logic signed [18:0] s4_q_in, s4_q_ff, s4_p_ff;
   logic [16:0]        s4_l_ff;
   logic               s4_grey_ff;
   logic [8:0]         s4_t_ff [NUM_CHAN];

   // stage 5
   logic signed [18:0] diff;
   logic [17:0]        d;
   sector_info_type    sec [NUM_CHAN];
   logic [23:0]        s5_m_ff [NUM_CHAN];
   sector_type         s5_sel_ff [NUM_CHAN];
   logic signed [18:0] s5_q_ff, s5_p_ff;
   logic [16:0]        s5_l_ff;
   logic               s5_grey_ff;

   // stage 6
   logic [48:0]        s6_qp_ff [NUM_CHAN];
   sector_type         s6_sel_ff [NUM_CHAN];
   logic signed [18:0] s6_q_ff, s6_p_ff;
   logic [16:0]        s6_l_ff;
   logic               s6_grey_ff;

   // stage 7
   logic signed [19:0] s7_v_in [NUM_CHAN];
   logic signed [19:0] s7_v_ff [NUM_CHAN];

   // output and skid
   logic [23:0] pipe_data;
   logic        pipe_out;
   logic        out_vld_ff, skid_vld_ff;
   logic [23:0] out_data_ff, skid_data_ff;
   logic        take;

   assign en         = !skid_vld_ff;
   assign req_tready = en;

   assign hue = req_tdata[15:0];
   assign sat = req_tdata[31:16];
   assign lit = req_tdata[47:32];

   assign sat_cl = ({16'b0, sat} > FULL_PCT) ? FULL_PCT[15:0] : sat;
   assign lit_cl = ({16'b0, lit} > FULL_PCT) ? FULL_PCT[15:0] : lit;
   assign sat_y  = 23'(({16'b0, sat_cl} << PCT_SH) + 32'd50);
   assign lit_y  = 23'(({16'b0, lit_cl} << PCT_SH) + 32'd50);

   assign hue_quot = s1_hprod_ff[32:25];
   assign s2_hm_in = 9'(s1_hue_ff - 16'(hue_quot) * 16'(DEG_360));

   assign tr_sum = 10'(s2_hm_ff) + 10'(DEG_120);
   assign tb_sum = 10'(s2_hm_ff) + 10'(DEG_240);
   assign s3_t_in[0] = (tr_sum >= 10'(DEG_360)) ? 9'(tr_sum - 10'(DEG_360)) : 9'(tr_sum);
   assign s3_t_in[1] = s2_hm_ff;
   assign s3_t_in[2] = (tb_sum >= 10'(DEG_360)) ? 9'(tb_sum - 10'(DEG_360)) : 9'(tb_sum);

   assign ls      = s3_lsp_ff[32:16];
   assign s4_q_in = (s3_l_ff < 17'(HALF_Q16))
                  ? 19'(s3_l_ff) + 19'(ls)
                  : 19'(s3_l_ff) + 19'(s3_s_ff) - 19'(ls);

   assign diff = s4_q_ff - s4_p_ff;
   assign d    = diff[18] ? 18'd0 : diff[17:0];

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         sec[c] = sector_of(s4_t_ff[c]);
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (s6_grey_ff) begin
            s7_v_in[c] = 20'(s6_l_ff);
         end else begin
            case (s6_sel_ff[c])
               SEC_HIGH: s7_v_in[c] = 20'(s6_q_ff);
               SEC_LOW:  s7_v_in[c] = 20'(s6_p_ff);
               default:  s7_v_in[c] = 20'(s6_p_ff) + 20'(s6_qp_ff[c][47:30]);
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sprod_ff <= 47'(sat_y) * 47'(RECIP_100);
         s1_lprod_ff <= 47'(lit_y) * 47'(RECIP_100);
         s1_hprod_ff <= 33'(hue) * 33'(RECIP_360);
         s1_hue_ff   <= hue;

         s2_s_ff  <= s1_sprod_ff[46:30];
         s2_l_ff  <= s1_lprod_ff[46:30];
         s2_hm_ff <= s2_hm_in;

         s3_lsp_ff <= 34'(s2_l_ff) * 34'(s2_s_ff) + 34'(HALF_Q16);
         s3_s_ff   <= s2_s_ff;
         s3_l_ff   <= s2_l_ff;

         s4_q_ff    <= s4_q_in;
         s4_p_ff    <= (19'(s3_l_ff) <<< 1) - s4_q_in;
         s4_l_ff    <= s3_l_ff;
         s4_grey_ff <= (s3_s_ff == 17'd0);

         s5_q_ff    <= s4_q_ff;
         s5_p_ff    <= s4_p_ff;
         s5_l_ff    <= s4_l_ff;
         s5_grey_ff <= s4_grey_ff;

         s6_q_ff    <= s5_q_ff;
         s6_p_ff    <= s5_p_ff;
         s6_l_ff    <= s5_l_ff;
         s6_grey_ff <= s5_grey_ff;

         for (int c = 0; c < NUM_CHAN; c++) begin
            s3_t_ff[c]   <= s3_t_in[c];
            s4_t_ff[c]   <= s3_t_ff[c];
            s5_m_ff[c]   <= 24'(d) * 24'(sec[c].weight) + 24'd30;
            s5_sel_ff[c] <= sec[c].sel;
            s6_qp_ff[c]  <= 49'(s5_m_ff[c]) * 49'(RECIP_60);
            s6_sel_ff[c] <= s5_sel_ff[c];
            s7_v_ff[c]   <= s7_v_in[c];
         end
      end
   end

   assign pipe_data = {to_byte(s7_v_ff[2]), to_byte(s7_v_ff[1]), to_byte(s7_v_ff[0])};
   assign pipe_out  = vld_ff[6] && en;
   assign take      = out_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!out_vld_ff || take) begin
         out_vld_ff  <= skid_vld_ff || pipe_out;
         skid_vld_ff <= 1'b0;
      end else if (pipe_out) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_vld_ff || take) begin
         out_data_ff <= skid_vld_ff ? skid_data_ff : pipe_data;
      end else if (pipe_out) begin
         skid_data_ff <= pipe_data;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_vld_ff |-> out_vld_ff)
      else $error("skid holds an item while output register is empty");

   a_hue_reduced: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (s2_hm_ff < DEG_360))
      else $error("hue not reduced below 360");

   a_q16_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (s2_s_ff <= 17'(ONE_Q16)) && (s2_l_ff <= 17'(ONE_Q16)))
      else $error("saturation or lightness above 1.0 in Q16");

   a_p_below_q: assert property (@(posedge clock) disable iff (reset)
      vld_ff[3] |-> (s4_p_ff <= s4_q_ff))
      else $error("intermediate p above q");

endmodule

// ----- dv/hsl_to_rgb_checker.sv -----
`timescale 1ns / 1ps

module hsl_to_rgb_checker
   import h2rgb_pkg::*;
#(
   parameter int PERCENT_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,   // hue_degrees, saturation_pct, lightness_pct
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // red, green, blue
   output int          failures,
   output int          pending
);

   localparam longint UNIT_Q16 = longint'(ONE_Q16);
   localparam longint MID_Q16  = longint'(HALF_Q16);
   localparam longint FULL_PCT = longint'(100) << PERCENT_FRAC_BITS;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb_t;

   typedef struct {
      logic [15:0] hue;
      logic [15:0] sat;
      logic [15:0] light;
      rgb_t        rgb;
   } color_item_t;

   color_item_t expected_colors[$];
   color_item_t want;
   rgb_t        got;
   int          fail_count = 0;

   function automatic longint pct_to_frac(input logic [15:0] pct);
      longint v;
      v = longint'(pct);
      if (v > FULL_PCT)
         v = FULL_PCT;
      return (v * UNIT_Q16 + FULL_PCT / 2) / FULL_PCT;
   endfunction

   function automatic longint level_at(input longint p, input longint q, input int t);
      longint d;
      d = q - p;
      if (d < 0)
         d = 0;
      if (t < 60)
         return p + (d * t + 30) / 60;
      else if (t < 180)
         return q;
      else if (t < 240)
         return p + (d * (240 - t) + 30) / 60;
      else
         return p;
   endfunction

   function automatic logic [7:0] level_to_byte(input longint v);
      longint r;
      if (v <= 0)
         return 8'd0;
      r = (v * 255 + MID_Q16) / UNIT_Q16;
      if (r > 255)
         r = 255;
      return 8'(r);
   endfunction

   function automatic rgb_t predict_rgb(input logic [15:0] hue, input logic [15:0] sat,
                                        input logic [15:0] light);
      int     h;
      longint s, l, ls, q, p, r, g, b;
      rgb_t   c;
      h = int'(hue) % 360;
      s = pct_to_frac(sat);
      l = pct_to_frac(light);
      r = l;
      g = l;
      b = l;
      if (s > 0) begin
         ls = (l * s + MID_Q16) / UNIT_Q16;
         q  = (l < MID_Q16) ? l + ls : l + s - ls;
         p  = 2 * l - q;
         r  = level_at(p, q, (h + 120) % 360);
         g  = level_at(p, q, h);
         b  = level_at(p, q, (h + 240) % 360);
      end
      c.red   = level_to_byte(r);
      c.green = level_to_byte(g);
      c.blue  = level_to_byte(b);
      return c;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         expected_colors.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            want.hue   = req_tdata[15:0];
            want.sat   = req_tdata[31:16];
            want.light = req_tdata[47:32];
            want.rgb   = predict_rgb(want.hue, want.sat, want.light);
            expected_colors.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_colors.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected rgb item %0d/%0d/%0d", $realtime,
                           got.red, got.green, got.blue);
            end else begin
               want = expected_colors.pop_front();
               if (got.red !== want.rgb.red || got.green !== want.rgb.green ||
                   got.blue !== want.rgb.blue) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: hsl %0d/%0d/%0d rgb expected %0d/%0d/%0d got %0d/%0d/%0d",
                              $realtime, want.hue, want.sat, want.light, want.rgb.red,
                              want.rgb.green, want.rgb.blue, got.red, got.green, got.blue);
               end
            end
         end
      end
      pending  <= expected_colors.size();
      failures <= fail_count;
   end

   initial begin
      pending  = 0;
      failures = 0;
   end

endmodule

// ----- dv/hsl_to_rgb_converter_test.sv -----
`timescale 1ns / 1ps

module hsl_to_rgb_converter_test;

   localparam int FULL_PCT = 100 << 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // hue_degrees, saturation_pct, lightness_pct
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // red, green, blue
   logic        full_rate  = 1'b0;
   int          ready_hold = 0;
   int          failures;
   int          pending;

   hsl_to_rgb_converter #(.PERCENT_FRAC_BITS(8)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   hsl_to_rgb_checker #(.PERCENT_FRAC_BITS(8)) scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .failures   (failures),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [15:0] pick_pct();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8)
         return 16'd0;
      else if (r < 14)
         return 16'(FULL_PCT);
      else if (r < 24)
         return 16'($urandom_range(0, 65535));
      else
         return 16'($urandom_range(0, FULL_PCT));
   endfunction

   always @(posedge clock) begin
      if (reset || full_rate) begin
         rsp_tready <= 1'b1;
         ready_hold <= 0;
      end else if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= ($urandom_range(0, 2) != 0);
         ready_hold <= pick_gap();
      end
   end

   task automatic send_color(input logic [15:0] hue, input logic [15:0] sat,
                             input logic [15:0] light);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {light, sat, hue};
      do @(posedge clock); while (!req_tready);
      gap = full_rate ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      logic [15:0] hue;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // primaries, sector edges, clamps, grey and extremes
      send_color(16'd0,     16'd25600, 16'd12800);
      send_color(16'd120,   16'd25600, 16'd12800);
      send_color(16'd240,   16'd25600, 16'd12800);
      send_color(16'd59,    16'd25600, 16'd12800);
      send_color(16'd60,    16'd25600, 16'd12800);
      send_color(16'd179,   16'd25600, 16'd12800);
      send_color(16'd180,   16'd25600, 16'd12800);
      send_color(16'd239,   16'd25600, 16'd12800);
      send_color(16'd359,   16'd25600, 16'd12800);
      send_color(16'd360,   16'd25600, 16'd12800);
      send_color(16'd65535, 16'd65535, 16'd65535);
      send_color(16'd0,     16'd0,     16'd0);
      send_color(16'd300,   16'd0,     16'd12800);
      send_color(16'd30,    16'd0,     16'd65535);
      send_color(16'd90,    16'd65535, 16'd6400);
      send_color(16'd200,   16'd1,     16'd1);
      send_color(16'd45,    16'd12800, 16'd25600);
      send_color(16'd45,    16'd12800, 16'd0);
      send_color(16'd150,   16'd25601, 16'd12801);
      send_color(16'd210,   16'd12800, 16'd19200);
      send_color(16'd330,   16'd25599, 16'd12799);
      send_color(16'd719,   16'd256,   16'd32768);
      send_color(16'd65535, 16'd0,     16'd65535);

      for (int i = 0; i < 1000; i++) begin
         if (i % 64 == 0)
            full_rate <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 9) < 7)
            hue = 16'($urandom_range(0, 359));
         else
            hue = 16'($urandom_range(0, 65535));
         send_color(hue, pick_pct(), pick_pct());
      end
      req_tvalid <= 1'b0;

      // let the count of the last item reach pending
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (failures == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
